### hw/rtl/dcdc_pkg.sv
package dcdc_pkg;

    localparam int EPOCH_YEAR = 2000;
    localparam logic [8:0] YEAR_DAYS = 9'd365;

    localparam logic [25:0] RECIP_365 = 26'd47068135;
    localparam int RECIP_365_SHIFT = 34;
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int RECIP_100_SHIFT = 19;
    localparam logic [5:0] CENT_4000 = 6'd40;
    localparam logic [6:0] CENT_YEARS = 7'd100;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic        mode;
        logic [16:0] days;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        bad;
    } item_t;

    typedef struct packed {
        item_t       it;
        logic [11:0] ysel;
    } s1_t;

    typedef struct packed {
        item_t       it;
        logic [11:0] ysel;
        logic [20:0] p365;
        logic [5:0]  q100y;
        logic [5:0]  q100x;
    } s2_t;

    typedef struct packed {
        item_t       it;
        logic [11:0] ysel;
        logic [20:0] ys;
        logic        leapy;
        logic        leapx;
    } s3_t;

    typedef struct packed {
        item_t       it;
        logic [11:0] yfin;
        logic [8:0]  rem;
        logic        leap;
        logic [16:0] dn;
    } s4_t;

    // Day number of January 1st of the year that follows the span.
    function automatic int span_days(int span);
        int s;
        s = span - 1;
        if (span > 0)
        begin
            return 365 * span + s / 4 - s / 100 + s / 400 - s / 4000 + 1;
        end
        return 0;
    endfunction

    // Leap rule on a year offset, given the offset divided by 100.
    function automatic logic is_leap(logic [11:0] v, logic [5:0] q100);
        logic cent;
        logic mod400;
        logic mod4000;
        cent = ((12'(q100) * 12'(CENT_YEARS)) == v);
        mod400 = cent && (q100[1:0] == 2'd0);
        mod4000 = cent && ((q100 == 6'd0) || (q100 == CENT_4000));
        return (v == 12'd0) || ((v[1:0] == 2'd0) && !cent) || (mod400 && !mod4000);
    endfunction

    // Days of the year that come before the first day of month m.
    function automatic logic [8:0] month_start(logic [3:0] m, logic leap);
        logic [8:0] base;
        unique case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd365;
        endcase
        return base + 9'(leap && (m > MONTH_FEB) && (m <= MONTH_DEC));
    endfunction

    function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

### hw/rtl/day_count_date_converter.sv
// Converts between a day number counted from 2000-01-01 and a Gregorian date.
// An item is taken when start is high and busy is low. busy stays low, so an
// item may be started in every clock cycle. With mode low the item carries a
// day number and the result carries the date; with mode high the item carries
// a date and the result carries its day number.
// The result of an item appears on the result ports for one cycle, marked by
// done, once the item has passed the stage registers s1_reg to s4_reg and the
// output registers. Results leave in the order the items came in, one per item.
// The receiver cannot stall the block.
// invalid marks a day number or year outside the YEAR_SPAN years from 2000,
// or a month or day that does not exist; every other field of such a result is zero.
// The latency is set by a five-stage pipeline: a reciprocal multiply for the
// year estimate, the constant multiplies of the year start, the leap count
// sum, the year correction or day number sum, and the month search.
// Reset clears the valid bits of every stage, so items in flight are dropped
// and done stays low until new items reach the end of the pipeline.
module day_count_date_converter #(
    parameter int YEAR_SPAN = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [16:0] day_number,
    input  logic [11:0] year_in,
    input  logic [3:0]  month_in,
    input  logic [4:0]  day_in,
    output logic        done,
    output logic [11:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [16:0] days_out,
    output logic        invalid
);
    import dcdc_pkg::*;

    localparam logic [12:0] YEAR_END = 13'(EPOCH_YEAR + YEAR_SPAN);
    localparam logic [20:0] SPAN_DAYS = 21'(span_days(YEAR_SPAN));

    logic v1_reg, v2_reg, v3_reg, v4_reg, done_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;

    logic [11:0] year_out_reg, year_out_next;
    logic [3:0]  month_out_reg, month_out_next;
    logic [4:0]  day_out_reg, day_out_next;
    logic [16:0] days_out_reg, days_out_next;
    logic        invalid_reg, invalid_next;

    logic [42:0] quot_prod;
    logic [11:0] year_off;
    logic        bad_days;
    logic        bad_date;

    logic [11:0] s2_x;
    logic [24:0] prod_y;
    logic [24:0] prod_x;

    logic [11:0] s3_x;
    logic [11:0] leaps;

    logic [21:0] rem_a;
    logic [21:0] rem_b;
    logic        dec;
    logic [20:0] dn_sum;
    logic        day_bad;

    logic [3:0]  mon;
    logic [8:0]  mon_base;
    logic [8:0]  day_rem;
    logic [3:0]  k_mon;
    int          k;

    assign busy = 1'b0;

    always_comb
    begin
        quot_prod = 43'(day_number) * 43'(RECIP_365);
        year_off = year_in - 12'(EPOCH_YEAR);
        bad_days = ({4'b0, day_number} >= SPAN_DAYS);
        bad_date = (year_in < 12'(EPOCH_YEAR)) || ({1'b0, year_in} >= YEAR_END) ||
                   (month_in < MONTH_JAN) || (month_in > MONTH_DEC);

        s1_next.it.mode = mode;
        s1_next.it.days = day_number;
        s1_next.it.year = year_in;
        s1_next.it.month = month_in;
        s1_next.it.day = day_in;
        s1_next.it.bad = mode ? bad_date : bad_days;
        s1_next.ysel = mode ? year_off : 12'(quot_prod[RECIP_365_SHIFT +: 9]);
    end

    always_comb
    begin
        s2_x = s1_reg.ysel - 12'd1;
        prod_y = 25'(s1_reg.ysel) * 25'(RECIP_100);
        prod_x = 25'(s2_x) * 25'(RECIP_100);

        s2_next.it = s1_reg.it;
        s2_next.ysel = s1_reg.ysel;
        s2_next.p365 = 21'(s1_reg.ysel) * 21'(YEAR_DAYS);
        s2_next.q100y = prod_y[RECIP_100_SHIFT +: 6];
        s2_next.q100x = prod_x[RECIP_100_SHIFT +: 6];
    end

    always_comb
    begin
        s3_x = s2_reg.ysel - 12'd1;
        leaps = 12'(s3_x[11:2]) - 12'(s2_reg.q100x) + 12'(s2_reg.q100x[5:2]) -
                12'(s2_reg.q100x >= CENT_4000) + 12'd1;

        s3_next.it = s2_reg.it;
        s3_next.ysel = s2_reg.ysel;
        s3_next.ys = s2_reg.p365 + ((s2_reg.ysel == 12'd0) ? 21'd0 : 21'(leaps));
        s3_next.leapy = is_leap(s2_reg.ysel, s2_reg.q100y);
        s3_next.leapx = is_leap(s3_x, s2_reg.q100x);
    end

    always_comb
    begin
        rem_a = {5'b0, s3_reg.it.days} - {1'b0, s3_reg.ys};
        dec = rem_a[21];
        rem_b = rem_a + 22'(YEAR_DAYS) + 22'(s3_reg.leapx);
        dn_sum = s3_reg.ys + 21'(month_start(s3_reg.it.month, s3_reg.leapy)) +
                 21'(s3_reg.it.day) - 21'd1;
        day_bad = (s3_reg.it.day == 5'd0) ||
                  (s3_reg.it.day > month_len(s3_reg.it.month, s3_reg.leapy));

        s4_next.it = s3_reg.it;
        s4_next.it.bad = s3_reg.it.bad || (s3_reg.it.mode && day_bad);
        s4_next.yfin = dec ? (s3_reg.ysel - 12'd1) : s3_reg.ysel;
        s4_next.rem = dec ? rem_b[8:0] : rem_a[8:0];
        s4_next.leap = dec ? s3_reg.leapx : s3_reg.leapy;
        s4_next.dn = s3_reg.it.mode ? dn_sum[16:0] : s3_reg.it.days;
    end

    always_comb
    begin
        mon = MONTH_JAN;
        mon_base = 9'd0;
        for (k = 1; k < 12; k++)
        begin
            k_mon = 4'(k + 1);
            if (s4_reg.rem >= month_start(k_mon, s4_reg.leap))
            begin
                mon = k_mon;
                mon_base = month_start(k_mon, s4_reg.leap);
            end
        end
        day_rem = s4_reg.rem - mon_base + 9'd1;

        invalid_next = s4_reg.it.bad;
        if (s4_reg.it.bad)
        begin
            year_out_next = 12'd0;
            month_out_next = 4'd0;
            day_out_next = 5'd0;
            days_out_next = 17'd0;
        end
        else if (s4_reg.it.mode)
        begin
            year_out_next = s4_reg.it.year;
            month_out_next = s4_reg.it.month;
            day_out_next = s4_reg.it.day;
            days_out_next = s4_reg.dn;
        end
        else
        begin
            year_out_next = s4_reg.yfin + 12'(EPOCH_YEAR);
            month_out_next = mon;
            day_out_next = day_rem[4:0];
            days_out_next = s4_reg.dn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_reg <= s1_next;
        end
        if (v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (v2_reg)
        begin
            s3_reg <= s3_next;
        end
        if (v3_reg)
        begin
            s4_reg <= s4_next;
        end
        if (v4_reg)
        begin
            year_out_reg <= year_out_next;
            month_out_reg <= month_out_next;
            day_out_reg <= day_out_next;
            days_out_reg <= days_out_next;
            invalid_reg <= invalid_next;
        end
    end

    assign done = done_reg;
    assign year_out = year_out_reg;
    assign month_out = month_out_reg;
    assign day_out = day_out_reg;
    assign days_out = days_out_reg;
    assign invalid = invalid_reg;

endmodule

### hw/rtl/dcdc_checker.sv
module dcdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        mode,
    input logic [16:0] day_number,
    input logic [11:0] year_in,
    input logic [3:0]  month_in,
    input logic [4:0]  day_in,
    input logic        done,
    input logic [11:0] year_out,
    input logic [3:0]  month_out,
    input logic [4:0]  day_out,
    input logic [16:0] days_out,
    input logic        invalid
);

    // Every accepted item gives a result, marked by done.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("item accepted without a result five cycles later");

    // No result appears without a matching item taken before it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result without a matching item");

    // A rejected item carries only zero fields.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && invalid) |-> (year_out == 12'd0 && month_out == 4'd0 &&
                               day_out == 5'd0 && days_out == 17'd0))
        else $error("invalid result with nonzero fields");

    // A good result holds a real month and day.
    a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !invalid) |-> (month_out >= 4'd1 && month_out <= 4'd12 &&
                                day_out >= 5'd1 && day_out <= 5'd31))
        else $error("valid result with a month or day out of range");

endmodule

bind day_count_date_converter dcdc_checker u_dcdc_checker (.*);

### tb/tb_day_count_date_converter.sv
`timescale 1ns / 100ps

module tb_day_count_date_converter;

    localparam int CLK_PERIOD = 12;
    localparam int YEAR_SPAN = 256;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 12;

    localparam logic MODE_TO_DATE = 1'b0;
    localparam logic MODE_TO_DAYS = 1'b1;

    localparam int unsigned EPOCH = dcdc_pkg::EPOCH_YEAR;
    localparam int unsigned SPAN_DAYS = 365 * YEAR_SPAN + (YEAR_SPAN - 1) / 4
        - (YEAR_SPAN - 1) / 100 + (YEAR_SPAN - 1) / 400 - (YEAR_SPAN - 1) / 4000 + 1;

    typedef struct {
        logic        mode;
        logic [16:0] day_number;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        bit          drain_first;
    } date_req_t;

    typedef struct {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [16:0] days;
        logic        invalid;
    } date_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        mode = 1'b0;
    logic [16:0] day_number = '0;
    logic [11:0] year_in = '0;
    logic [3:0]  month_in = '0;
    logic [4:0]  day_in = '0;
    logic        done;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [16:0] days_out;
    logic        invalid;

    date_req_t    pending_requests[$];
    date_result_t expected_dates[$];
    date_req_t    driven_req;
    int           gap_left = 0;
    int           burst_left = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;

    day_count_date_converter #(
        .YEAR_SPAN(YEAR_SPAN)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .day_number(day_number),
        .year_in(year_in),
        .month_in(month_in),
        .day_in(day_in),
        .done(done),
        .year_out(year_out),
        .month_out(month_out),
        .day_out(day_out),
        .days_out(days_out),
        .invalid(invalid)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit leap_offset(int unsigned y);
        return (y == 0) || ((y % 4 == 0) && (y % 100 != 0)) ||
               ((y % 400 == 0) && (y % 4000 != 0));
    endfunction

    function automatic int unsigned year_first_day(int unsigned y);
        int unsigned p;
        if (y == 0)
        begin
            return 0;
        end
        p = y - 1;
        return 365 * y + p / 4 - p / 100 + p / 400 - p / 4000 + 1;
    endfunction

    function automatic int unsigned month_days(int unsigned m, bit leap);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic date_result_t convert_date(date_req_t req);
        date_result_t res;
        int unsigned  y;
        int unsigned  rest;
        int unsigned  m;
        int unsigned  total;
        res = '{default: '0};
        res.invalid = 1'b0;
        if (req.mode == MODE_TO_DATE)
        begin
            if (req.day_number >= SPAN_DAYS)
            begin
                res.invalid = 1'b1;
            end
            else
            begin
                y = req.day_number / 365;
                while (y > 0 && year_first_day(y) > req.day_number)
                begin
                    y--;
                end
                rest = req.day_number - year_first_day(y);
                m = 1;
                while (m < 12 && rest >= month_days(m, leap_offset(y)))
                begin
                    rest -= month_days(m, leap_offset(y));
                    m++;
                end
                res.year = 12'(y + EPOCH);
                res.month = 4'(m);
                res.day = 5'(rest + 1);
                res.days = req.day_number;
            end
        end
        else if (req.year < EPOCH || req.year >= EPOCH + YEAR_SPAN ||
                 req.month < 1 || req.month > 12)
        begin
            res.invalid = 1'b1;
        end
        else
        begin
            y = req.year - EPOCH;
            if (req.day == 0 || req.day > month_days(req.month, leap_offset(y)))
            begin
                res.invalid = 1'b1;
            end
            else
            begin
                total = year_first_day(y);
                for (m = 1; m < req.month; m++)
                begin
                    total += month_days(m, leap_offset(y));
                end
                total += req.day - 1;
                res.year = req.year;
                res.month = req.month;
                res.day = req.day;
                res.days = 17'(total);
            end
        end
        return res;
    endfunction

    task automatic queue_request(input logic md, input int unsigned dn, input int unsigned yr,
                                 input int unsigned mo, input int unsigned dy);
        date_req_t req;
        req.mode = md;
        req.day_number = 17'(dn);
        req.year = 12'(yr);
        req.month = 4'(mo);
        req.day = 5'(dy);
        req.drain_first = 1'b0;
        pending_requests.push_back(req);
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            mode <= 1'b0;
            day_number <= '0;
            year_in <= '0;
            month_in <= '0;
            day_in <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_dates.push_back(convert_date(driven_req));
            end
            if (start && busy)
            begin
                start <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_requests.size() > 0 &&
                     !(pending_requests[0].drain_first && expected_dates.size() > 0))
            begin
                driven_req = pending_requests.pop_front();
                start <= 1'b1;
                mode <= driven_req.mode;
                day_number <= driven_req.day_number;
                year_in <= driven_req.year;
                month_in <= driven_req.month;
                day_in <= driven_req.day;
                if (burst_left > 0)
                begin
                    burst_left <= burst_left - 1;
                    gap_left <= 0;
                end
                else if ($urandom_range(0, 99) < 3)
                begin
                    burst_left <= $urandom_range(20, 80);
                    gap_left <= 0;
                end
                else if ($urandom_range(0, 99) < 55)
                begin
                    gap_left <= 0;
                end
                else if ($urandom_range(0, 99) < 90)
                begin
                    gap_left <= $urandom_range(1, 4);
                end
                else
                begin
                    gap_left <= $urandom_range(10, 40);
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        date_result_t want;
        if (rst_n && done)
        begin
            if (expected_dates.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %0d-%0d-%0d days %0d inv %0b",
                         $time, year_out, month_out, day_out, days_out, invalid);
                mismatch_count++;
            end
            else
            begin
                want = expected_dates.pop_front();
                check_field("year_out", want.year, year_out);
                check_field("month_out", want.month, month_out);
                check_field("day_out", want.day, day_out);
                check_field("days_out", want.days, days_out);
                check_field("invalid", want.invalid, invalid);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_day_count_date_converter failed");
            $finish;
        end
    end

    initial
    begin
        date_req_t   req;
        int unsigned pick;
        int unsigned yoff;
        int unsigned len;

        queue_request(MODE_TO_DATE, 0, 0, 0, 0);
        queue_request(MODE_TO_DATE, 59, 0, 0, 0);
        queue_request(MODE_TO_DATE, 60, 0, 0, 0);
        queue_request(MODE_TO_DATE, 365, 0, 0, 0);
        queue_request(MODE_TO_DATE, 366, 0, 0, 0);
        queue_request(MODE_TO_DATE, 36524, 0, 0, 0);
        queue_request(MODE_TO_DATE, 36525, 0, 0, 0);
        queue_request(MODE_TO_DATE, SPAN_DAYS - 1, 0, 0, 0);
        queue_request(MODE_TO_DATE, SPAN_DAYS, 0, 0, 0);
        queue_request(MODE_TO_DATE, 131071, 4095, 15, 31);
        queue_request(MODE_TO_DAYS, 0, 2000, 1, 1);
        queue_request(MODE_TO_DAYS, 131071, EPOCH + YEAR_SPAN - 1, 12, 31);
        queue_request(MODE_TO_DAYS, 0, EPOCH + YEAR_SPAN, 1, 1);
        queue_request(MODE_TO_DAYS, 0, 1999, 12, 31);
        queue_request(MODE_TO_DAYS, 0, 0, 0, 0);
        queue_request(MODE_TO_DAYS, 0, 4095, 15, 31);
        queue_request(MODE_TO_DAYS, 0, 2000, 2, 29);
        queue_request(MODE_TO_DAYS, 0, 2100, 2, 29);
        queue_request(MODE_TO_DAYS, 0, 2004, 2, 29);
        queue_request(MODE_TO_DAYS, 0, 2001, 2, 30);
        queue_request(MODE_TO_DAYS, 0, 2023, 4, 31);
        queue_request(MODE_TO_DAYS, 0, 2023, 13, 5);
        queue_request(MODE_TO_DAYS, 0, 2023, 6, 0);
        queue_request(MODE_TO_DAYS, 0, 2023, 1, 31);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            req.day_number = 17'($urandom);
            req.year = 12'($urandom);
            req.month = 4'($urandom);
            req.day = 5'($urandom);
            req.drain_first = (i % 350 == 349);
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                req.mode = MODE_TO_DATE;
                if ($urandom_range(0, 99) < 20)
                begin
                    yoff = year_first_day($urandom_range(0, YEAR_SPAN));
                    req.day_number = 17'((yoff > 0) ? yoff - $urandom_range(0, 1) : 0);
                end
                else
                begin
                    req.day_number = 17'($urandom_range(0, SPAN_DAYS - 1));
                end
            end
            else if (pick < 80)
            begin
                req.mode = MODE_TO_DAYS;
                yoff = $urandom_range(0, YEAR_SPAN - 1);
                req.year = 12'(EPOCH + yoff);
                req.month = 4'($urandom_range(1, 12));
                len = month_days(req.month, leap_offset(yoff));
                if ($urandom_range(0, 99) < 75)
                begin
                    req.day = 5'($urandom_range(1, len));
                end
                else
                begin
                    req.day = 5'($urandom_range(0, 31));
                end
            end
            else if (pick < 90)
            begin
                req.mode = MODE_TO_DATE;
            end
            else
            begin
                req.mode = MODE_TO_DAYS;
                if ($urandom_range(0, 1) == 0)
                begin
                    req.year = 12'($urandom_range(EPOCH - 2, EPOCH + YEAR_SPAN + 1));
                end
            end
            pending_requests.push_back(req);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() > 0 || start || expected_dates.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_dates.size() == 0)
        begin
            $display("tb_day_count_date_converter passed");
        end
        else
        begin
            $display("tb_day_count_date_converter failed");
        end
        $finish;
    end

endmodule

### day_count_date_converter.f
hw/rtl/dcdc_pkg.sv
hw/rtl/day_count_date_converter.sv
hw/rtl/dcdc_checker.sv
tb/tb_day_count_date_converter.sv
